@@ src/ts_to_rtp_packetizer_pcr_stamp_core_assert.svh @@
// Assertion macros for the packetizer; clocked on i_clk, off while i_rst_n is low.
`ifndef TS_TO_RTP_PACKETIZER_PCR_STAMP_CORE_ASSERT_SVH
`define TS_TO_RTP_PACKETIZER_PCR_STAMP_CORE_ASSERT_SVH

// Same-cycle implication.
`define TSRTP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsrtp same-cycle check failed");

// Next-cycle implication.
`define TSRTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsrtp next-cycle check failed");

`endif

@@ src/tsrtp_pkg.sv @@
package tsrtp_pkg;

    localparam int TS_PACKET_BYTES = 188;
    localparam int PPD_DEFAULT     = 7;
    localparam int PKT_IDX_W       = 8;
    localparam int GRP_W           = 3;
    localparam int LEN_W           = 11;
    localparam int PCR_W           = 33;

    // Header byte positions inside a TS packet
    localparam logic [PKT_IDX_W-1:0] AFC_BYTE       = 8'd3;
    localparam logic [PKT_IDX_W-1:0] AF_FLAGS_BYTE  = 8'd5;
    localparam logic [PKT_IDX_W-1:0] PCR_FIRST_BYTE = 8'd6;
    localparam logic [PKT_IDX_W-1:0] PCR_LAST_BYTE  = 8'd10;

    localparam logic [7:0] AF_PRESENT_BIT = 8'h20;
    localparam logic [1:0] AF_ONLY_CODE   = 2'b10;
    localparam logic [7:0] PCR_FLAG_MASK  = 8'h10;

    localparam logic [6:0] PAYLOAD_TYPE_RESET = 7'd33;

    // Configuration register indexes
    localparam logic [1:0] CFG_PAYLOAD_TYPE   = 2'd0;
    localparam logic [1:0] CFG_START_SSRC     = 2'd1;
    localparam logic [1:0] CFG_START_SEQUENCE = 2'd2;

    typedef struct packed {
        logic [7:0] ts_byte;
        logic       end_of_buffer;
    } t_ts_in;

    typedef struct packed {
        logic [15:0]      sequence_number;
        logic [31:0]      rtp_timestamp;
        logic [31:0]      sync_source;
        logic [6:0]       header_payload_type;
        logic [LEN_W-1:0] payload_length;
        logic             pcr_seen;
    } t_rtp_hdr;

    typedef struct packed {
        logic             close;
        logic             has_pcr;
        logic [31:0]      pcr_low;
        logic [LEN_W-1:0] payload_count;
    } t_grp_status;

endpackage

@@ src/tsrtp_parse.sv @@
module tsrtp_parse
    import tsrtp_pkg::*;
#(
    parameter int PACKETS_PER_DATAGRAM = PPD_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_ts_in      i_in,
    output t_grp_status o_status
);

    localparam logic [GRP_W-1:0] PPD = GRP_W'(PACKETS_PER_DATAGRAM);
    localparam logic [PKT_IDX_W-1:0] PKT_LAST = PKT_IDX_W'(TS_PACKET_BYTES);

    logic [PKT_IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [GRP_W-1:0]     r_pkt_idx, n_pkt_idx;
    logic [LEN_W-1:0]     r_count, n_count;
    logic                 r_af_only, n_af_only;
    logic                 r_pcr_flag, n_pcr_flag;
    logic [PCR_W-1:0]     r_pcr, n_pcr;
    logic                 r_has_pcr, n_has_pcr;

    logic [PKT_IDX_W-1:0] byte_inc;
    logic [GRP_W-1:0]     pkt_inc;
    logic [LEN_W-1:0]     count_inc;
    logic                 pkt_done;
    logic                 close;
    logic                 capture;
    logic                 af_only_now;
    logic                 pcr_flag_now;
    logic [PCR_W-1:0]     pcr_now;
    logic                 has_pcr_now;

    always_comb begin
        byte_inc  = r_byte_idx + 1'b1;
        pkt_inc   = r_pkt_idx + 1'b1;
        count_inc = r_count + 1'b1;
        pkt_done  = (byte_inc == PKT_LAST);
        close     = i_in.end_of_buffer || (pkt_done && (pkt_inc >= PPD));

        af_only_now  = r_af_only;
        pcr_flag_now = r_pcr_flag;
        pcr_now      = r_pcr;
        has_pcr_now  = r_has_pcr;
        capture      = (r_byte_idx >= PCR_FIRST_BYTE) && (r_byte_idx <= PCR_LAST_BYTE)
                       && !r_has_pcr && r_af_only && r_pcr_flag;

        if (r_byte_idx == AFC_BYTE) begin
            af_only_now = ((i_in.ts_byte & AF_PRESENT_BIT) != 8'd0)
                          && (i_in.ts_byte[5:4] == AF_ONLY_CODE);
        end else if (r_byte_idx == AF_FLAGS_BYTE) begin
            pcr_flag_now = ((i_in.ts_byte & PCR_FLAG_MASK) != 8'd0);
        end else if (capture) begin
            if (r_byte_idx != PCR_LAST_BYTE) begin
                pcr_now = {r_pcr[PCR_W-9:0], i_in.ts_byte};
            end else begin
                // only the top bit of the last byte belongs to the base
                pcr_now     = {r_pcr[PCR_W-2:0], i_in.ts_byte[7]};
                has_pcr_now = 1'b1;
            end
        end

        o_status.close         = close;
        o_status.has_pcr       = has_pcr_now;
        o_status.pcr_low       = pcr_now[31:0];
        o_status.payload_count = count_inc;

        priority if (close) begin
            n_byte_idx = '0;
            n_pkt_idx  = '0;
            n_count    = '0;
            n_af_only  = 1'b0;
            n_pcr_flag = 1'b0;
            n_pcr      = '0;
            n_has_pcr  = 1'b0;
        end else if (pkt_done) begin
            n_byte_idx = '0;
            n_pkt_idx  = pkt_inc;
            n_count    = count_inc;
            n_af_only  = 1'b0;
            n_pcr_flag = 1'b0;
            n_pcr      = pcr_now;
            n_has_pcr  = has_pcr_now;
        end else begin
            n_byte_idx = byte_inc;
            n_pkt_idx  = r_pkt_idx;
            n_count    = count_inc;
            n_af_only  = af_only_now;
            n_pcr_flag = pcr_flag_now;
            n_pcr      = pcr_now;
            n_has_pcr  = has_pcr_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= '0;
            r_pkt_idx  <= '0;
            r_count    <= '0;
            r_af_only  <= 1'b0;
            r_pcr_flag <= 1'b0;
            r_pcr      <= '0;
            r_has_pcr  <= 1'b0;
        end else if (i_en) begin
            r_byte_idx <= n_byte_idx;
            r_pkt_idx  <= n_pkt_idx;
            r_count    <= n_count;
            r_af_only  <= n_af_only;
            r_pcr_flag <= n_pcr_flag;
            r_pcr      <= n_pcr;
            r_has_pcr  <= n_has_pcr;
        end
    end

endmodule

@@ src/ts_to_rtp_packetizer_pcr_stamp_core.sv @@
// Transport stream to RTP header stamper. One TS byte is taken per cycle, every
// cycle, as long as the result side keeps up: the byte, packet and PCR capture
// counters update in the accepting cycle and a closing byte loads the header
// register in the same cycle. A finished header sits in an output register backed
// by one skid entry, so the input stalls only when two headers wait untaken. A
// header is produced when PACKETS_PER_DATAGRAM packets of 188 bytes have passed or
// a byte flagged end_of_buffer arrives. Configuration writes are taken every cycle;
// writing the start SSRC or start sequence loads the running value at once.
module ts_to_rtp_packetizer_pcr_stamp_core
    import tsrtp_pkg::*;
#(
    parameter int PACKETS_PER_DATAGRAM = PPD_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_ts_in      i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rtp_hdr    o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic        accept;
    logic        take;
    logic        produce;
    t_grp_status status;
    t_rtp_hdr    hdr;

    logic [6:0]  r_ptype;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_ssrc, n_ssrc;
    logic [31:0] r_ts, n_ts;
    logic        seen;

    logic        r_out_valid;
    t_rtp_hdr    r_out;
    logic        r_skid_valid;
    t_rtp_hdr    r_skid;

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign take        = r_out_valid && i_out_ready;
    assign produce     = accept && status.close;

    tsrtp_parse #(
        .PACKETS_PER_DATAGRAM(PACKETS_PER_DATAGRAM)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_in     (i_in),
        .o_status (status)
    );

    always_comb begin
        seen   = status.has_pcr && (status.pcr_low != 32'd0);
        n_ts   = seen ? status.pcr_low : r_ts;
        n_seq  = r_seq + 1'b1;
        // bump the source id when the sequence wraps
        n_ssrc = (n_seq == 16'd0) ? r_ssrc + 1'b1 : r_ssrc;

        hdr.sequence_number     = n_seq;
        hdr.rtp_timestamp       = n_ts;
        hdr.sync_source         = n_ssrc;
        hdr.header_payload_type = r_ptype;
        hdr.payload_length      = status.payload_count;
        hdr.pcr_seen            = seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptype <= PAYLOAD_TYPE_RESET;
            r_seq   <= '0;
            r_ssrc  <= '0;
            r_ts    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAYLOAD_TYPE:   r_ptype <= i_cfg_data[6:0];
                CFG_START_SSRC:     r_ssrc  <= i_cfg_data;
                CFG_START_SEQUENCE: r_seq   <= i_cfg_data[15:0];
                default: ;
            endcase
        end else if (produce) begin
            r_seq  <= n_seq;
            r_ssrc <= n_ssrc;
            r_ts   <= n_ts;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || produce;
            r_skid_valid <= 1'b0;
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : hdr;
        end
        if (produce && r_out_valid && !take) begin
            r_skid <= hdr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`include "ts_to_rtp_packetizer_pcr_stamp_core_assert.svh"

    `TSRTP_ASSERT_IMPLY(a_skid_behind_out, r_skid_valid, r_out_valid)
    `TSRTP_ASSERT_NEXT(a_stalled_out_holds, r_out_valid && !i_out_ready, r_out_valid)
    `TSRTP_ASSERT_IMPLY(a_length_nonzero, r_out_valid, r_out.payload_length != '0)
    `TSRTP_ASSERT_IMPLY(a_pcr_stamp_nonzero, r_out_valid && r_out.pcr_seen,
        r_out.rtp_timestamp != 32'd0)

endmodule

@@ verif/ts_to_rtp_packetizer_pcr_stamp_core_tb.sv @@
`timescale 1ns / 100ps

module ts_to_rtp_packetizer_pcr_stamp_core_tb;
    import tsrtp_pkg::*;

    localparam int PPD            = PPD_DEFAULT;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        bit          use_hdr;
        logic [7:0]  afc;
        logic [7:0]  flags;
        logic [32:0] pcr;
    } t_pkt_hdr;

    typedef struct {
        bit          cfg;
        logic [6:0]  pt;
        logic [31:0] ssrc;
        logic [15:0] seq;
        int          nbytes;
        bit          eob;
        t_pkt_hdr    h;
        logic [7:0]  fill;
        bit          typed;
        t_rtp_hdr    exp_hdr;
    } t_dir_row;

    localparam t_pkt_hdr NO_HDR = '{1'b0, 8'h00, 8'h00, 33'h0};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_ready;
    t_ts_in      in_item;
    logic        o_out_valid;
    logic        out_ready;
    t_rtp_hdr    o_out;
    logic        cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    logic [6:0]       hdr_pt;
    logic [31:0]      cur_ssrc;
    logic [15:0]      cur_seq;
    logic [31:0]      cur_ts;
    logic [7:0]       pkt_pos;
    logic [2:0]       pkt_cnt;
    logic [LEN_W-1:0] byte_cnt;
    logic             af_only;
    logic             pcr_flag;
    logic [PCR_W-1:0] pcr_acc;
    logic             grp_pcr;

    t_rtp_hdr hdr_expected[$];
    int       errors;
    int       sent_bytes;
    int       closed_count;
    int       idle_cycles;
    bit       quiet;

    t_dir_row dir_rows [15] = '{
        '{0, 7'd0, 32'h0, 16'h0, 1, 1, NO_HDR, 8'h00,
          1, '{16'd1, 32'h0, 32'h0, 7'd33, 11'd1, 1'b0}},
        '{0, 7'd0, 32'h0, 16'h0, 1, 1, NO_HDR, 8'hFF,
          1, '{16'd2, 32'h0, 32'h0, 7'd33, 11'd1, 1'b0}},
        // buffer ends right after the last PCR byte, sync byte not 0x47
        '{0, 7'd0, 32'h0, 16'h0, 11, 1, '{1'b1, 8'h20, 8'h10, 33'h1_2345_6789}, 8'hA5,
          1, '{16'd3, 32'h2345_6789, 32'h0, 7'd33, 11'd11, 1'b1}},
        // buffer ends before the last PCR byte: timestamp held
        '{0, 7'd0, 32'h0, 16'h0, 10, 1, '{1'b1, 8'h20, 8'h10, 33'h0_1111_1111}, 8'h11,
          1, '{16'd4, 32'h2345_6789, 32'h0, 7'd33, 11'd10, 1'b0}},
        // adaptation plus payload: no capture
        '{0, 7'd0, 32'h0, 16'h0, 188, 0, '{1'b1, 8'h30, 8'h10, 33'h0_0BAD_BEEF}, 8'h5A,
          0, '0},
        // no PCR flag
        '{0, 7'd0, 32'h0, 16'h0, 188, 0, '{1'b1, 8'h20, 8'h00, 33'h0_0BAD_BEEF}, 8'h3C,
          0, '0},
        // first match has zero low bits and still blocks the next one
        '{0, 7'd0, 32'h0, 16'h0, 188, 0, '{1'b1, 8'h20, 8'h10, 33'h1_0000_0000}, 8'h00,
          0, '0},
        '{0, 7'd0, 32'h0, 16'h0, 188, 0, '{1'b1, 8'h20, 8'h10, 33'h0_0000_0002}, 8'h00,
          0, '0},
        '{0, 7'd0, 32'h0, 16'h0, 188, 0, NO_HDR, 8'hFF, 0, '0},
        '{0, 7'd0, 32'h0, 16'h0, 188, 0, NO_HDR, 8'h00, 0, '0},
        // last packet of the datagram and buffer end together
        '{0, 7'd0, 32'h0, 16'h0, 188, 1, NO_HDR, 8'h55,
          1, '{16'd5, 32'h2345_6789, 32'h0, 7'd33, 11'd1316, 1'b0}},
        '{1, 7'd127, 32'hFFFF_FFFF, 16'hFFFE, 1, 1, NO_HDR, 8'h80,
          1, '{16'hFFFF, 32'h2345_6789, 32'hFFFF_FFFF, 7'd127, 11'd1, 1'b0}},
        // sequence wraps, SSRC wraps with it
        '{0, 7'd0, 32'h0, 16'h0, 1, 1, NO_HDR, 8'h01,
          1, '{16'h0000, 32'h2345_6789, 32'h0, 7'd127, 11'd1, 1'b0}},
        '{1, 7'd0, 32'h0, 16'h8000, 11, 1, '{1'b1, 8'hE0, 8'hFF, 33'h1_FFFF_FFFF}, 8'h7F,
          1, '{16'h8001, 32'hFFFF_FFFF, 32'h0, 7'd0, 11'd11, 1'b1}},
        '{0, 7'd0, 32'h0, 16'h0, 20, 1, '{1'b1, 8'h20, 8'h10, 33'h0_0000_0001}, 8'hC3,
          0, '0}
    };

    ts_to_rtp_packetizer_pcr_stamp_core #(
        .PACKETS_PER_DATAGRAM(PPD)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out      (o_out),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ready <= quiet || ($urandom_range(99) >= 24);
    end

    // One TS byte through the header stamper; returns the header it closes, if any.
    task automatic packetize_byte(input t_ts_in it, output bit closed, output t_rtp_hdr hdr);
        logic [7:0] b;
        bit         pkt_done;
        bit         seen;
        b = it.ts_byte;
        closed = 1'b0;
        seen = 1'b0;
        hdr = '0;
        if (pkt_pos == AFC_BYTE) begin
            af_only = ((b & AF_PRESENT_BIT) != 0) && (b[5:4] == AF_ONLY_CODE);
        end else if (pkt_pos == AF_FLAGS_BYTE) begin
            pcr_flag = (b & PCR_FLAG_MASK) != 0;
        end else if (pkt_pos >= PCR_FIRST_BYTE && pkt_pos <= PCR_LAST_BYTE && !grp_pcr
                     && af_only && pcr_flag) begin
            if (pkt_pos < PCR_LAST_BYTE) begin
                pcr_acc = {pcr_acc[PCR_W-9:0], b};
            end else begin
                pcr_acc = {pcr_acc[PCR_W-2:0], b[7]};
                grp_pcr = 1'b1;
            end
        end
        byte_cnt = byte_cnt + 1'b1;
        pkt_pos = pkt_pos + 1'b1;
        pkt_done = (pkt_pos >= TS_PACKET_BYTES);
        if (pkt_done) begin
            pkt_pos = '0;
            af_only = 1'b0;
            pcr_flag = 1'b0;
            pkt_cnt = pkt_cnt + 1'b1;
        end
        if (it.end_of_buffer || (pkt_done && pkt_cnt >= PPD)) begin
            if (grp_pcr && pcr_acc[31:0] != 0) begin
                cur_ts = pcr_acc[31:0];
                seen = 1'b1;
            end
            cur_seq = cur_seq + 1'b1;
            if (cur_seq == 0) cur_ssrc = cur_ssrc + 1'b1;
            hdr.sequence_number     = cur_seq;
            hdr.rtp_timestamp       = cur_ts;
            hdr.sync_source         = cur_ssrc;
            hdr.header_payload_type = hdr_pt;
            hdr.payload_length      = byte_cnt;
            hdr.pcr_seen            = seen;
            closed = 1'b1;
            pkt_pos = '0;
            af_only = 1'b0;
            pcr_flag = 1'b0;
            pkt_cnt = '0;
            byte_cnt = '0;
            pcr_acc = '0;
            grp_pcr = 1'b0;
        end
    endtask

    function automatic logic [7:0] ts_pkt_byte(input t_pkt_hdr h, input int pos,
                                               input logic [7:0] fill);
        if (!h.use_hdr) return fill;
        if (pos == AFC_BYTE) return h.afc;
        if (pos == AF_FLAGS_BYTE) return h.flags;
        if (pos >= PCR_FIRST_BYTE && pos < PCR_LAST_BYTE)
            return 8'(h.pcr >> (8 * (int'(PCR_LAST_BYTE) - 1 - pos) + 1));
        if (pos == PCR_LAST_BYTE) return {h.pcr[0], fill[6:0]};
        return fill;
    endfunction

    function automatic t_pkt_hdr rand_pkt_hdr();
        t_pkt_hdr h;
        h.use_hdr = ($urandom_range(99) < 70);
        h.afc = 8'($urandom);
        if ($urandom_range(99) < 80) h.afc[5:4] = AF_ONLY_CODE;
        h.flags = 8'($urandom);
        if ($urandom_range(99) < 80) h.flags = h.flags | PCR_FLAG_MASK;
        h.pcr = {1'($urandom), 32'($urandom)};
        if ($urandom_range(99) < 10) h.pcr[31:0] = '0;
        return h;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eob,
                             output bit closed, output t_rtp_hdr hdr);
        t_ts_in it;
        it.ts_byte = b;
        it.end_of_buffer = eob;
        while (!quiet && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        packetize_byte(it, closed, hdr);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    // Bytes 0..nbytes-1 of one TS packet; a typed header overrides the predicted one.
    task automatic send_segment(input t_pkt_hdr h, input int nbytes, input bit eob_end,
                                input bit rand_fill, input logic [7:0] fill,
                                input bit typed, input t_rtp_hdr typed_hdr);
        bit         closed;
        t_rtp_hdr   hdr;
        logic [7:0] f;
        for (int k = 0; k < nbytes; k++) begin
            f = rand_fill ? 8'($urandom) : fill;
            send_byte(ts_pkt_byte(h, k, f), eob_end && (k == nbytes - 1), closed, hdr);
            if (closed) begin
                hdr_expected.push_back(typed ? typed_hdr : hdr);
                closed_count++;
            end
        end
    endtask

    task automatic send_random_buffer;
        int       shape;
        int       npk;
        int       tail;
        t_pkt_hdr h;
        shape = $urandom_range(99);
        h = rand_pkt_hdr();
        if (shape < 75) begin
            npk = 0;
            tail = $urandom_range(1, 16);
        end else if (shape < 90) begin
            npk = 1;
            tail = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24);
        end else begin
            // noise: no header structure at all
            npk = 0;
            tail = $urandom_range(1, 32);
            h.use_hdr = 1'b0;
        end
        for (int p = 0; p < npk; p++)
            send_segment(rand_pkt_hdr(), TS_PACKET_BYTES, (tail == 0) && (p == npk - 1),
                         1'b1, 8'h00, 1'b0, '0);
        if (tail > 0) send_segment(h, tail, 1'b1, 1'b1, 8'h00, 1'b0, '0);
    endtask

    // Hold the sender until every header has come out, then let the core settle.
    task automatic drain;
        in_valid <= 1'b0;
        while (hdr_expected.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [6:0] pt, input logic [31:0] ssrc,
                              input logic [15:0] seq);
        logic [1:0]  idx [3];
        logic [31:0] val [3];
        idx = '{CFG_PAYLOAD_TYPE, CFG_START_SSRC, CFG_START_SEQUENCE};
        val = '{{25'd0, pt}, ssrc, {16'd0, seq}};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[i])
                CFG_PAYLOAD_TYPE:   hdr_pt = val[i][6:0];
                CFG_START_SSRC:     cur_ssrc = val[i];
                CFG_START_SEQUENCE: cur_seq = val[i][15:0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rtp_hdr want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (hdr_expected.size() == 0) begin
                $display("%0t: header with nothing expected, actual seq %0h", $time,
                         o_out.sequence_number);
                errors++;
            end else begin
                want = hdr_expected.pop_front();
                check_field("sequence_number", 32'(want.sequence_number),
                            32'(o_out.sequence_number));
                check_field("rtp_timestamp", want.rtp_timestamp, o_out.rtp_timestamp);
                check_field("sync_source", want.sync_source, o_out.sync_source);
                check_field("header_payload_type", 32'(want.header_payload_type),
                            32'(o_out.header_payload_type));
                check_field("payload_length", 32'(want.payload_length),
                            32'(o_out.payload_length));
                check_field("pcr_seen", 32'(want.pcr_seen), 32'(o_out.pcr_seen));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
            || (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d headers pending", $time,
                     hdr_expected.size());
            $display("ts_to_rtp_packetizer_pcr_stamp_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int start_res;
        int start_bytes;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PAYLOAD_TYPE;
        cfg_data  = '0;
        quiet     = 1'b0;
        errors = 0;
        sent_bytes = 0;
        closed_count = 0;
        idle_cycles = 0;
        hdr_pt   = PAYLOAD_TYPE_RESET;
        cur_ssrc = '0;
        cur_seq  = '0;
        cur_ts   = '0;
        pkt_pos  = '0;
        pkt_cnt  = '0;
        byte_cnt = '0;
        af_only  = 1'b0;
        pcr_flag = 1'b0;
        pcr_acc  = '0;
        grp_pcr  = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < $size(dir_rows); r++) begin
            if (dir_rows[r].cfg) begin
                drain();
                write_regs(dir_rows[r].pt, dir_rows[r].ssrc, dir_rows[r].seq);
            end
            send_segment(dir_rows[r].h, dir_rows[r].nbytes, dir_rows[r].eob, 1'b0,
                         dir_rows[r].fill, dir_rows[r].typed, dir_rows[r].exp_hdr);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                1:       write_regs(7'd127, 32'hFFFF_FFFF, 16'hFFFE);
                2:       write_regs(7'd0, 32'h0, 16'h0);
                default: write_regs(7'($urandom), $urandom, 16'($urandom));
            endcase
            quiet = (ph == 2);
            start_res = closed_count;
            start_bytes = sent_bytes;
            while (closed_count - start_res < ((ph == 2) ? 6 : 3)
                   || sent_bytes - start_bytes < 40)
                send_random_buffer();
        end
        quiet = 1'b0;

        drain();
        repeat (4) @(negedge i_clk);
        if (errors == 0 && hdr_expected.size() == 0)
            $display("ts_to_rtp_packetizer_pcr_stamp_core_tb: PASS");
        else
            $display("ts_to_rtp_packetizer_pcr_stamp_core_tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/tsrtp_pkg.sv
src/tsrtp_parse.sv
src/ts_to_rtp_packetizer_pcr_stamp_core.sv
verif/ts_to_rtp_packetizer_pcr_stamp_core_tb.sv
